/* rtl/ritx_pkg.sv */
package ritx_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int DIGIT_SLOTS_DEF = 32;

	localparam int RADIX_W = 6;
	localparam int CHAR_W  = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h37;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < RADIX_DEC) begin
			res = CHAR_ZERO + {2'b00, d};
		end else begin
			res = CHAR_ALPHA + {2'b00, d};
		end
		return res;
	endfunction

endpackage

/* rtl/ritx_ram.sv */
module ritx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/ritx_div.sv */
module ritx_div #(
	parameter int VALUE_WIDTH = ritx_pkg::VALUE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [VALUE_WIDTH-1:0]       dividend,
	input  logic [ritx_pkg::RADIX_W-1:0] divisor,
	output ritx_pkg::div_stat_t          stat,
	output logic [VALUE_WIDTH-1:0]       quotient,
	output logic [ritx_pkg::RADIX_W-1:0] remainder
);

	localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	logic                         running_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [VALUE_WIDTH-1:0]       dq_q;
	logic [ritx_pkg::RADIX_W-1:0] rem_q;
	logic [ritx_pkg::RADIX_W-1:0] div_q;

	logic [ritx_pkg::RADIX_W:0]   trial;
	logic                         fits;
	logic [ritx_pkg::RADIX_W:0]   diff;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, dq_q[VALUE_WIDTH-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= CNT_W'(VALUE_WIDTH - 1);
			end else if (running_q) begin
				if (cnt_q == '0) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (running_q) begin
			dq_q  <= {dq_q[VALUE_WIDTH-2:0], fits};
			rem_q <= fits ? diff[ritx_pkg::RADIX_W-1:0] : trial[ritx_pkg::RADIX_W-1:0];
		end
	end

	assign stat.busy = running_q;
	assign stat.done = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

/* rtl/integer_to_radix_text.sv */
// integer_to_radix_text
// Converts one signed integer per input word into ASCII text in the radix
// held by the configuration register (2..36, out-of-range codes clamp).
// s_tdata carries value in its low VALUE_WIDTH bits. Each output word is
// one character on m_tdata, most significant digit first; m_tlast marks
// the final character of a value. In radix ten a negative value is sent
// as '-' and its magnitude; other radices read the bits as unsigned.
// cfg_wen/cfg_wdata write the radix (reset 10); the user must write it
// only while the block is idle, which the block itself does not enforce.
// Each digit comes from one pass of the bit-serial divider (one quotient
// bit per cycle) and is stored in the digit RAM; the characters are then
// read back through its read port, the sign first. s_tready is high only
// between values, so one value is converted at a time; the next value is
// taken while the last character still sits in the output register.
// Reset clears the sequencer and output valid and sets radix to ten.
// A stalled receiver holds the output register and the sequencer waits.
module integer_to_radix_text #(
	parameter int VALUE_WIDTH = ritx_pkg::VALUE_WIDTH_DEF,
	parameter int DIGIT_SLOTS = ritx_pkg::DIGIT_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [ritx_pkg::RADIX_W-1:0]       cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]   s_tdata,  // value
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ritx_pkg::CHAR_W-1:0]        m_tdata,  // character
	output logic                               m_tlast   // last_char
);

	localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
	localparam int ADR_W = $clog2(DIGIT_SLOTS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_SIGN = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;

	logic [2:0]                   state_q;
	logic [ritx_pkg::RADIX_W-1:0] radix_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         sign_q;
	logic                         out_valid_q;
	logic [ritx_pkg::CHAR_W-1:0]  out_char_q;
	logic                         out_last_q;

	logic [ritx_pkg::RADIX_W-1:0] base;
	logic [VALUE_WIDTH-1:0]       in_val;
	logic                         show_sign;
	logic [VALUE_WIDTH-1:0]       magnitude;
	logic                         accept;
	logic                         out_free;
	logic                         out_load;
	logic                         more;
	logic [CNT_W-1:0]             cnt_inc;
	logic [CNT_W-1:0]             cnt_dec;

	logic                         div_start;
	logic [VALUE_WIDTH-1:0]       div_dividend;
	ritx_pkg::div_stat_t          div_stat;
	logic [VALUE_WIDTH-1:0]       div_quot;
	logic [ritx_pkg::RADIX_W-1:0] div_rem;

	logic                         ram_we;
	logic                         ram_re;
	logic [ritx_pkg::CHAR_W-1:0]  ram_rdata;

	assign base      = ritx_pkg::clamp_radix(radix_q);
	assign in_val    = s_tdata[VALUE_WIDTH-1:0];
	assign show_sign = (base == ritx_pkg::RADIX_DEC) && in_val[VALUE_WIDTH-1];
	assign magnitude = show_sign ? (~in_val + VALUE_WIDTH'(1)) : in_val;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = ((state_q == S_SIGN) || (state_q == S_LOAD)) && out_free;
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign cnt_dec  = cnt_q - CNT_W'(1);
	assign more     = (div_quot != '0) && (cnt_inc < CNT_W'(DIGIT_SLOTS));

	assign ram_we       = (state_q == S_DIV) && div_stat.done;
	assign ram_re       = (state_q == S_RD);
	assign div_start    = accept || (ram_we && more);
	assign div_dividend = accept ? magnitude : div_quot;

	ritx_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (base),
		.stat     (div_stat),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	ritx_ram #(
		.WIDTH(ritx_pkg::CHAR_W),
		.DEPTH(DIGIT_SLOTS)
	) u_digits (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[ADR_W-1:0]),
		.wdata(ritx_pkg::digit_char(div_rem)),
		.re   (ram_re),
		.raddr(cnt_dec[ADR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= ritx_pkg::RADIX_RESET;
		end else if (cfg_wen) begin
			radix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						sign_q  <= show_sign;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// store one digit per divider pass, least significant first
					if (div_stat.done) begin
						cnt_q <= cnt_inc;
						if (!more) begin
							state_q <= sign_q ? S_SIGN : S_RD;
						end
					end
				end
				S_SIGN: begin
					if (out_free) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					cnt_q   <= cnt_dec;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					// hold the read data until the output register frees up
					if (out_free) begin
						state_q <= (cnt_q == '0) ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_SIGN) && out_free) begin
			out_char_q <= ritx_pkg::CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if ((state_q == S_LOAD) && out_free) begin
			out_char_q <= ram_rdata;
			out_last_q <= (cnt_q == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> div_stat.busy && (state_q == S_DIV))
		else $error("accepted value did not start the divider");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_digit_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cnt_q < CNT_W'(DIGIT_SLOTS)))
		else $error("digit write beyond the digit slots");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (cnt_q != '0))
		else $error("digit read with no digits left");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import ritx_pkg::*;

	typedef struct {
		logic [RADIX_W-1:0] radix_code;
		logic [31:0]        value;
		string              text;   // empty: take the text from the predictor
	} dir_row_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [RADIX_W-1:0]   cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata = '0;   // value
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [CHAR_W-1:0]    m_tdata;        // character
	logic                 m_tlast;        // last_char

	logic [RADIX_W-1:0]   cfg_radix = RADIX_RESET;
	text_char_t           text_q[$];
	int                   mismatches = 0;
	int                   send_idle_pct = 13;
	int                   recv_idle_pct = 54;

	dir_row_t dir_rows [22] = '{
		'{6'd10, 32'd0,          "0"},
		'{6'd10, 32'h7FFFFFFF,   "2147483647"},
		'{6'd10, 32'h80000000,   "-2147483648"},
		'{6'd10, 32'hFFFFFFFF,   "-1"},
		'{6'd10, 32'd9,          "9"},
		'{6'd10, 32'd10,         "10"},
		'{6'd10, 32'd12345,      ""},
		'{6'd10, -32'sd907,      ""},
		'{6'd16, 32'hFFFFFFFF,   "FFFFFFFF"},
		'{6'd16, 32'd255,        "FF"},
		'{6'd16, 32'h80000000,   "80000000"},
		'{6'd16, 32'd0,          "0"},
		'{6'd2,  32'd0,          "0"},
		'{6'd2,  32'hFFFFFFFF,   "11111111111111111111111111111111"},
		'{6'd2,  32'd5,          "101"},
		'{6'd36, 32'd35,         "Z"},
		'{6'd36, 32'hFFFFFFFF,   ""},
		'{6'd0,  32'd6,          "110"},
		'{6'd1,  32'd2,          "10"},
		'{6'd37, 32'd35,         "Z"},
		'{6'd63, 32'd36,         "10"},
		'{6'd8,  32'hFFFFFFF8,   ""}
	};

	integer_to_radix_text dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #6 clk = ~clk;

	task automatic predict_text(input logic [31:0] v);
		logic [RADIX_W-1:0] base;
		logic               signed_dec;
		logic [31:0]        q;
		logic [31:0]        d;
		logic [CHAR_W-1:0]  digits [32];
		int                 n;
		if (cfg_radix < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (cfg_radix > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = cfg_radix;
		end
		signed_dec = (base == RADIX_DEC) && v[31];
		q = signed_dec ? -v : v;
		n = 0;
		// least significant digit first, then emit in reverse
		do begin
			d = q % base;
			q = q / base;
			digits[n] = (d < RADIX_DEC) ? CHAR_ZERO + d[7:0] : CHAR_ALPHA + d[7:0];
			n++;
		end while (q != 0 && n < 32);
		if (signed_dec)
			text_q.push_back('{CHAR_MINUS, 1'b0});
		for (int i = n - 1; i >= 0; i--)
			text_q.push_back('{digits[i], i == 0});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back('{s[i], i == s.len() - 1});
	endtask

	// hold the word until accepted; the caller lowers tvalid when it stops sending
	task automatic send_value(input logic [31:0] v, input string text);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (text.len() == 0)
			predict_text(v);
		else
			push_text(text);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (text_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		cfg_wen   <= 1'b1;
		cfg_wdata <= r;
		cfg_radix = r;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [RADIX_W-1:0] pick_radix();
		logic [RADIX_W-1:0] extremes [6] = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63};
		if ($urandom_range(0, 2) == 0)
			return extremes[$urandom_range(0, 5)];
		return RADIX_W'($urandom_range(2, 36));
	endfunction

	function automatic logic [31:0] random_value();
		logic [31:0] edges [5] = '{32'd0, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000001};
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0, 1: begin
				v = $urandom;
			end
			2: begin
				v = $urandom >> $urandom_range(0, 31);
			end
			3: begin
				v = $urandom_range(0, 40);
			end
			default: begin
				v = edges[$urandom_range(0, 4)];
			end
		endcase
		if ($urandom_range(0, 3) == 0)
			v = -v;
		return v;
	endfunction

	always @(posedge clk) begin
		text_char_t exp_char;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (text_q.size() == 0) begin
					$error("character: no word expected, got %h", m_tdata);
					mismatches++;
				end else begin
					exp_char = text_q.pop_front();
					if (m_tdata !== exp_char.ch) begin
						$error("character: expected %h, got %h", exp_char.ch, m_tdata);
						mismatches++;
					end
					if (m_tlast !== exp_char.last) begin
						$error("last_char: expected %b, got %b", exp_char.last, m_tlast);
						mismatches++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; radix changes only once the text in flight is done
		foreach (dir_rows[i]) begin
			if (dir_rows[i].radix_code != cfg_radix) begin
				drain();
				write_radix(dir_rows[i].radix_code);
			end
			send_value(dir_rows[i].value, dir_rows[i].text);
		end

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 54;
				end
				1: begin
					send_idle_pct = 54;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				drain();
				write_radix(pick_radix());
				repeat (40) send_value(random_value(), "");
			end
		end

		drain();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(50_000_000);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
